[rtl/sbsh_pkg.sv]
`timescale 1ns / 1ps

package sbsh_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int KEY_WIDTH   = 32;
   localparam int CNT_W       = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int BIN_W       = $clog2(TABLE_DEPTH + 1);

   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;

   localparam int CMD_W       = 2;
   localparam int REQ_TDATA_W = ((ADDR_W + KEY_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((BIN_W + 2 * CNT_W + 7) / 8) * 8;
   localparam int RSP_PAD     = RSP_TDATA_W - BIN_W - 2 * CNT_W;

   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [KEY_WIDTH-1:0] key_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [BIN_W-1:0]     bin_type;
   typedef logic [QPTR_W-1:0]    qptr_type;
   typedef logic [QCNT_W-1:0]    qcnt_type;
   typedef logic [CSR_DW-1:0]    csr_data_type;

   localparam cnt_type CNT_MAX    = '1;
   localparam key_type KEY_SIGN   = {1'b1, {(KEY_WIDTH-1){1'b0}}};
   localparam bin_type USED_RESET = bin_type'(2);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_AW-3:0] {
      REG_MATCH_MODE   = 2'd0,
      REG_CLOSE_UPPER  = 2'd1,
      REG_USED_POINTS  = 2'd2
   } reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOW,
      S_HIGH,
      S_PROBE,
      S_FIND,
      S_CNT,
      S_READ,
      S_OUT
   } state_type;

   // key is stored sign-flipped so an unsigned compare orders signed values
   typedef struct packed {
      cmd_type  op;
      addr_type slot;
      key_type  key;
   } item_type;

   typedef struct packed {
      logic    match_mode;
      logic    close_upper;
      bin_type used_points;
   } cfg_type;

   typedef struct packed {
      bin_type bin_index;
      logic    found;
      cnt_type count_value;
      cnt_type miss_total;
   } result_type;

endpackage

[rtl/sorted_breakpoint_search_histogram_unit.sv]
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tuser: command; tdata: slot, key
// rsp_      out  rsp_tvalid/rsp_tready  tuser: found; tdata: bin_index, count, miss
// csr_      in   APB write/read         match_mode @0, close_upper @4, used_points @8
//
// A search reads the low and high end keys first, then narrows the window through
// the single key table read port, which serves one binary-search probe per cycle.
// Reset is synchronous; counters clear through per-entry valid bits, no sweep.
// A 2-entry request queue decouples intake from execution; a finished result
// waits in the output register while the next request is still accepted.

module sorted_breakpoint_search_histogram_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [7:0] slot, [39:8] key
   input  logic [sbsh_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [sbsh_pkg::CMD_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [8:0] bin_index, [40:9] count_value, [72:41] miss_total, rest zero
   output logic [sbsh_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] found
   output logic                             rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sbsh_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [sbsh_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [sbsh_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                             csr_pready
);

   sbsh_pkg::cfg_type    cfg;
   sbsh_pkg::item_type   q_head;
   logic                 q_valid;
   logic                 q_pop;
   sbsh_pkg::result_type rsp;

   sbsh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sbsh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   sbsh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {{sbsh_pkg::RSP_PAD{1'b0}}, rsp.miss_total, rsp.count_value,
                       rsp.bin_index};
   assign rsp_tuser = rsp.found;

endmodule

[rtl/sbsh_csr.sv]
`timescale 1ns / 1ps

module sbsh_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [sbsh_pkg::CSR_AW-1:0] csr_paddr,
   input  sbsh_pkg::csr_data_type     csr_pwdata,
   output sbsh_pkg::csr_data_type     csr_prdata,
   output logic                       csr_pready,
   output sbsh_pkg::cfg_type          cfg
);

   logic                 match_ff, match_in;
   logic                 closed_ff, closed_in;
   sbsh_pkg::bin_type    used_ff, used_in;
   sbsh_pkg::reg_type    reg_sel;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = sbsh_pkg::reg_type'(csr_paddr[sbsh_pkg::CSR_AW-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      match_in  = match_ff;
      closed_in = closed_ff;
      used_in   = used_ff;
      if (wr_en) begin
         unique case (reg_sel)
            sbsh_pkg::REG_MATCH_MODE:   match_in  = csr_pwdata[0];
            sbsh_pkg::REG_CLOSE_UPPER:  closed_in = csr_pwdata[0];
            sbsh_pkg::REG_USED_POINTS:  used_in   = csr_pwdata[sbsh_pkg::BIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff  <= 1'b0;
         closed_ff <= 1'b0;
         used_ff   <= sbsh_pkg::USED_RESET;
      end else begin
         match_ff  <= match_in;
         closed_ff <= closed_in;
         used_ff   <= used_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         sbsh_pkg::REG_MATCH_MODE:   csr_prdata[0] = match_ff;
         sbsh_pkg::REG_CLOSE_UPPER:  csr_prdata[0] = closed_ff;
         sbsh_pkg::REG_USED_POINTS:  csr_prdata    = sbsh_pkg::csr_data_type'(used_ff);
         default: ;
      endcase
   end

   assign cfg.match_mode   = match_ff;
   assign cfg.close_upper  = closed_ff;
   assign cfg.used_points  = used_ff;

endmodule

[rtl/sbsh_front.sv]
`timescale 1ns / 1ps

module sbsh_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sbsh_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [sbsh_pkg::CMD_W-1:0]      req_tuser,
   output logic                            q_valid,
   output sbsh_pkg::item_type              q_head,
   input  logic                            q_pop
);

   sbsh_pkg::item_type  q_ff [sbsh_pkg::QDEPTH];
   sbsh_pkg::item_type  in_item;
   sbsh_pkg::qptr_type  wr_ptr_ff, wr_ptr_in;
   sbsh_pkg::qptr_type  rd_ptr_ff, rd_ptr_in;
   sbsh_pkg::qcnt_type  cnt_ff, cnt_in;
   logic                push;
   logic                pop;

   // classify and pre-bias the request
   always_comb begin
      in_item.op   = sbsh_pkg::cmd_type'(req_tuser);
      in_item.slot = req_tdata[sbsh_pkg::ADDR_W-1:0];
      in_item.key  = req_tdata[sbsh_pkg::ADDR_W +: sbsh_pkg::KEY_WIDTH] ^ sbsh_pkg::KEY_SIGN;
   end

   assign req_tready = (cnt_ff != sbsh_pkg::qcnt_type'(sbsh_pkg::QDEPTH));
   assign q_valid    = (cnt_ff != '0);
   assign q_head     = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == sbsh_pkg::qptr_type'(sbsh_pkg::QDEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sbsh_pkg::qptr_type'(sbsh_pkg::QDEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[rtl/sbsh_back.sv]
`timescale 1ns / 1ps

module sbsh_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sbsh_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   input  sbsh_pkg::item_type   q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sbsh_pkg::result_type rsp
);

   sbsh_pkg::state_type  state_ff, state_in;
   sbsh_pkg::key_type    key_ff, key_in;
   sbsh_pkg::key_type    lo_key_ff, lo_key_in;
   sbsh_pkg::key_type    hi_key_ff, hi_key_in;
   sbsh_pkg::addr_type   lo_ff, lo_in;
   sbsh_pkg::addr_type   hi_ff, hi_in;
   sbsh_pkg::addr_type   mid_ff, mid_in;
   sbsh_pkg::addr_type   cidx_ff, cidx_in;
   sbsh_pkg::bin_type    res_bin_ff, res_bin_in;
   logic                 res_found_ff, res_found_in;
   sbsh_pkg::cnt_type    res_count_ff, res_count_in;
   sbsh_pkg::cnt_type    miss_ff, miss_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sbsh_pkg::result_type rsp_ff, rsp_in;

   // key table: one write, one registered read
   sbsh_pkg::key_type    key_mem [sbsh_pkg::TABLE_DEPTH];
   sbsh_pkg::key_type    key_rd_ff;
   logic                 key_we, key_re;
   sbsh_pkg::addr_type   key_wa, key_ra;
   sbsh_pkg::key_type    key_wd;

   // bin counters, with per-entry valid bits standing in for a clear sweep
   sbsh_pkg::cnt_type    cnt_mem [sbsh_pkg::TABLE_DEPTH];
   sbsh_pkg::cnt_type    cnt_rd_ff;
   logic [sbsh_pkg::TABLE_DEPTH-1:0] cnt_vld_ff;
   logic                 cnt_rd_vld_ff;
   logic                 cnt_we, cnt_re, cnt_clr;
   sbsh_pkg::addr_type   cnt_ra;
   sbsh_pkg::cnt_type    cnt_wd;

   sbsh_pkg::bin_type    n_eff;
   sbsh_pkg::addr_type   pts_last;
   logic                 few_points;
   logic                 x_lt_rd, x_gt_rd, go_lo;
   sbsh_pkg::addr_type   lo_nx, hi_nx, mid_now, mid_nx;
   logic                 more_now, more_nx;
   logic                 find_hit;
   sbsh_pkg::addr_type   find_cidx;
   sbsh_pkg::bin_type    find_bin;
   sbsh_pkg::cnt_type    cnt_old, cnt_bump, miss_bump;
   logic                 out_load;

   function automatic sbsh_pkg::addr_type midpoint(input sbsh_pkg::addr_type a,
                                                    input sbsh_pkg::addr_type b);
      sbsh_pkg::bin_type s;
      s = sbsh_pkg::bin_type'(a) + sbsh_pkg::bin_type'(b);
      return sbsh_pkg::addr_type'(s >> 1);
   endfunction

   // shared datapath terms
   always_comb begin
      n_eff = cfg.used_points;
      if (n_eff == '0) begin
         n_eff = sbsh_pkg::bin_type'(1);
      end else if (n_eff > sbsh_pkg::bin_type'(sbsh_pkg::TABLE_DEPTH)) begin
         n_eff = sbsh_pkg::bin_type'(sbsh_pkg::TABLE_DEPTH);
      end
      pts_last   = sbsh_pkg::addr_type'(n_eff - sbsh_pkg::bin_type'(1));
      few_points = !cfg.match_mode && (n_eff < sbsh_pkg::bin_type'(2));

      x_lt_rd = key_ff < key_rd_ff;
      x_gt_rd = key_ff > key_rd_ff;
      go_lo   = (cfg.close_upper && !cfg.match_mode) ? x_gt_rd : !x_lt_rd;
      lo_nx   = go_lo ? mid_ff : lo_ff;
      hi_nx   = go_lo ? hi_ff : mid_ff;
      mid_now = midpoint(lo_ff, hi_ff);
      mid_nx  = midpoint(lo_nx, hi_nx);
      more_now = sbsh_pkg::bin_type'(hi_ff) >
                 (sbsh_pkg::bin_type'(lo_ff) + sbsh_pkg::bin_type'(1));
      more_nx  = sbsh_pkg::bin_type'(hi_nx) >
                 (sbsh_pkg::bin_type'(lo_nx) + sbsh_pkg::bin_type'(1));

      find_hit  = 1'b0;
      find_cidx = lo_ff;
      find_bin  = '0;
      if (!cfg.match_mode) begin
         find_hit = 1'b1;
         find_bin = sbsh_pkg::bin_type'(hi_ff);
      end else if (key_ff == lo_key_ff) begin
         find_hit = 1'b1;
         find_bin = sbsh_pkg::bin_type'(lo_ff) + sbsh_pkg::bin_type'(1);
      end else if (key_ff == hi_key_ff) begin
         find_hit  = 1'b1;
         find_cidx = hi_ff;
         find_bin  = sbsh_pkg::bin_type'(hi_ff) + sbsh_pkg::bin_type'(1);
      end

      cnt_old   = cnt_rd_vld_ff ? cnt_rd_ff : '0;
      cnt_bump  = (cnt_old == sbsh_pkg::CNT_MAX) ? cnt_old : cnt_old + sbsh_pkg::cnt_type'(1);
      miss_bump = (miss_ff == sbsh_pkg::CNT_MAX) ? miss_ff : miss_ff + sbsh_pkg::cnt_type'(1);
      out_load  = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbsh_pkg::S_IDLE: begin
            if (q_valid) begin
               unique case (q_head.op) inside
                  sbsh_pkg::CMD_LOAD, sbsh_pkg::CMD_CLEAR: state_in = sbsh_pkg::S_OUT;
                  sbsh_pkg::CMD_READ: state_in = sbsh_pkg::S_READ;
                  sbsh_pkg::CMD_SEARCH:
                     state_in = few_points ? sbsh_pkg::S_OUT : sbsh_pkg::S_LOW;
               endcase
            end
         end
         sbsh_pkg::S_LOW:   state_in = x_lt_rd ? sbsh_pkg::S_OUT : sbsh_pkg::S_HIGH;
         sbsh_pkg::S_HIGH: begin
            if (x_gt_rd) begin
               state_in = sbsh_pkg::S_OUT;
            end else begin
               state_in = more_now ? sbsh_pkg::S_PROBE : sbsh_pkg::S_FIND;
            end
         end
         sbsh_pkg::S_PROBE: state_in = more_nx ? sbsh_pkg::S_PROBE : sbsh_pkg::S_FIND;
         sbsh_pkg::S_FIND:  state_in = find_hit ? sbsh_pkg::S_CNT : sbsh_pkg::S_OUT;
         sbsh_pkg::S_CNT:   state_in = sbsh_pkg::S_OUT;
         sbsh_pkg::S_READ:  state_in = sbsh_pkg::S_OUT;
         sbsh_pkg::S_OUT:   state_in = out_load ? sbsh_pkg::S_IDLE : sbsh_pkg::S_OUT;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      q_pop        = 1'b0;
      key_in       = key_ff;
      lo_key_in    = lo_key_ff;
      hi_key_in    = hi_key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      cidx_in      = cidx_ff;
      res_bin_in   = res_bin_ff;
      res_found_in = res_found_ff;
      res_count_in = res_count_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      key_we       = 1'b0;
      key_wa       = q_head.slot;
      key_wd       = q_head.key;
      key_re       = 1'b0;
      key_ra       = '0;
      cnt_we       = 1'b0;
      cnt_wd       = cnt_bump;
      cnt_re       = 1'b0;
      cnt_ra       = '0;
      cnt_clr      = 1'b0;

      unique case (state_ff)
         sbsh_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               key_in       = q_head.key;
               res_bin_in   = '0;
               res_found_in = 1'b0;
               res_count_in = '0;
               unique case (q_head.op)
                  sbsh_pkg::CMD_LOAD:  key_we = 1'b1;
                  sbsh_pkg::CMD_CLEAR: begin
                     cnt_clr = 1'b1;
                     miss_in = '0;
                  end
                  sbsh_pkg::CMD_READ: begin
                     cnt_re = 1'b1;
                     cnt_ra = q_head.slot;
                  end
                  sbsh_pkg::CMD_SEARCH: begin
                     if (few_points) begin
                        miss_in = miss_bump;
                     end else begin
                        key_re = 1'b1;
                        lo_in  = '0;
                        hi_in  = pts_last;
                     end
                  end
               endcase
            end
         end
         sbsh_pkg::S_LOW: begin
            lo_key_in = key_rd_ff;
            if (x_lt_rd) begin
               miss_in = miss_bump;
            end else begin
               key_re = 1'b1;
               key_ra = hi_ff;
            end
         end
         sbsh_pkg::S_HIGH: begin
            hi_key_in = key_rd_ff;
            if (x_gt_rd) begin
               miss_in = miss_bump;
            end else if (more_now) begin
               key_re = 1'b1;
               key_ra = mid_now;
               mid_in = mid_now;
            end
         end
         sbsh_pkg::S_PROBE: begin
            lo_in = lo_nx;
            hi_in = hi_nx;
            if (go_lo) begin
               lo_key_in = key_rd_ff;
            end else begin
               hi_key_in = key_rd_ff;
            end
            if (more_nx) begin
               key_re = 1'b1;
               key_ra = mid_nx;
               mid_in = mid_nx;
            end
         end
         sbsh_pkg::S_FIND: begin
            if (find_hit) begin
               cidx_in    = find_cidx;
               res_bin_in = find_bin;
               cnt_re     = 1'b1;
               cnt_ra     = find_cidx;
            end else begin
               miss_in = miss_bump;
            end
         end
         sbsh_pkg::S_CNT: begin
            cnt_we       = 1'b1;
            res_count_in = cnt_bump;
            res_found_in = 1'b1;
         end
         sbsh_pkg::S_READ: res_count_in = cnt_old;
         sbsh_pkg::S_OUT: begin
            if (out_load) begin
               rsp_valid_in       = 1'b1;
               rsp_in.bin_index   = res_bin_ff;
               rsp_in.found       = res_found_ff;
               rsp_in.count_value = res_count_ff;
               rsp_in.miss_total  = miss_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbsh_pkg::S_IDLE;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      lo_key_ff    <= lo_key_in;
      hi_key_ff    <= hi_key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      cidx_ff      <= cidx_in;
      res_bin_ff   <= res_bin_in;
      res_found_ff <= res_found_in;
      res_count_ff <= res_count_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= key_wd;
      end
      if (key_re) begin
         key_rd_ff <= key_mem[key_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cidx_ff] <= cnt_wd;
      end
      if (cnt_re) begin
         cnt_rd_ff     <= cnt_mem[cnt_ra];
         cnt_rd_vld_ff <= cnt_vld_ff[cnt_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cnt_clr) begin
         cnt_vld_ff <= '0;
      end else if (cnt_we) begin
         cnt_vld_ff[cidx_ff] <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   a_probe_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbsh_pkg::S_PROBE) |-> ((mid_ff > lo_ff) && (mid_ff < hi_ff)))
      else $error("probe address outside search window");

   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |->
         ((rsp_ff.bin_index != '0) && (rsp_ff.count_value != '0)))
      else $error("hit reported with zero bin or count");

   a_miss_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sbsh_pkg::S_IDLE) |=> (miss_ff >= $past(miss_ff)))
      else $error("miss total dropped outside a clear");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (q_head.op == sbsh_pkg::CMD_CLEAR)) |=>
         ((cnt_vld_ff == '0) && (miss_ff == '0)))
      else $error("clear left counters set");
`endif

endmodule
